/* src/matrix_multiply_top_macros.svh */
// Assertion macros for the matrix multiplier.
`ifndef MATRIX_MULTIPLY_TOP_MACROS_SVH
`define MATRIX_MULTIPLY_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MM_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("mm check failed");
`define MM_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("mm check failed");
`else
`define MM_ASSERT_IMPL(label, clk, rst, a, c)
`define MM_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

/* src/mm_pkg.sv */
// Shared types and constants for the matrix multiplier.
package mm_pkg;
  localparam int MaxDim = 32;
  localparam int ValueBits = 16;
  localparam int IdxBits = $clog2(MaxDim);
  localparam int AddrBits = 2 * IdxBits;
  localparam int SumBits = 48;
  localparam int DimBits = 6;

  typedef enum logic [1:0] {
    OP_WRITE_LEFT = 2'd0,
    OP_WRITE_RIGHT = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_LEFT_ROWS = 2'd0,
    REG_LEFT_COLS = 2'd1,
    REG_RIGHT_ROWS = 2'd2,
    REG_RIGHT_COLS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] row_index;
    logic [4:0] col_index;
    logic signed [15:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [4:0] out_row;
    logic [4:0] out_col;
    logic signed [47:0] product_value;
    logic dim_error;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic enable;
  } cell_ctl_t;
endpackage

/* src/matrix_multiply_top.sv */
// Matrix multiplier: element stores, cell chain and row output sequencer.
// Load items go straight into the stores. A compute feeds left_cols elements through the cells
// (left_cols counts as 0 on a size mismatch), drains, then emits right_cols beats,
// one per cycle when taken, and the next item is taken the cycle after the last beat.
// Right store: MaxDim column banks read one row per cycle; one cell per product column.
// Reset (synchronous, rst high) sets all sizes to 1 and idles; stores are not cleared.
`include "matrix_multiply_top_macros.svh"
module matrix_multiply_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mm_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mm_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [5:0]        cfg_data
);
  import mm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FEED = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  localparam int DrainLen = MaxDim + 3;
  localparam int CntBits = $clog2(DrainLen + 1);

  logic [DimBits-1:0] left_rows, left_cols, right_rows, right_cols;
  state_t state;
  logic [IdxBits:0] k, inner, ncols, j;
  logic [IdxBits-1:0] row;
  logic err;
  logic [CntBits-1:0] drain;

  in_item_t d;
  logic acc_in, is_wr;
  assign d = in_data;
  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign acc_in = in_valid && in_ready;
  assign is_wr = acc_in && (d.op == OP_WRITE_LEFT || d.op == OP_WRITE_RIGHT);

  function automatic logic [IdxBits:0] clampd(input logic [DimBits-1:0] v);
    return (v > DimBits'(MaxDim)) ? (IdxBits+1)'(MaxDim) : (IdxBits+1)'(v);
  endfunction

  // Left store: one RAM; right store: one RAM bank per column
  logic signed [ValueBits-1:0] left_rd;
  logic [ValueBits-1:0] left_raw;
  mm_ram #(.Width(ValueBits), .Depth(MaxDim*MaxDim)) u_left (
    .clk(clk), .we(is_wr && d.op == OP_WRITE_LEFT),
    .waddr({d.row_index[IdxBits-1:0], d.col_index[IdxBits-1:0]}),
    .wdata(d.element_value[ValueBits-1:0]),
    .raddr({row, k[IdxBits-1:0]}), .rdata(left_raw));
  assign left_rd = left_raw;

  logic signed [ValueBits-1:0] b_rd [MaxDim];
  logic signed [ValueBits-1:0] a_ch [MaxDim+1];
  logic signed [SumBits-1:0] accs [MaxDim];
  logic [ValueBits-1:0] b_skew [MaxDim][MaxDim];
  cell_ctl_t ctls [MaxDim];
  logic clear_go;
  logic feed_now;
  assign clear_go = acc_in && d.op == OP_COMPUTE;
  assign feed_now = (state == S_FEED) && (k < inner);

  // a leaves the left RAM in the cycle after the read; delay valid to match.
  logic v_rd;
  logic signed [ValueBits-1:0] a_zero;
  assign a_zero = v_rd ? left_rd : '0;
  assign a_ch[0] = a_zero;

  genvar c;
  generate
    for (c = 0; c < MaxDim; c++) begin : g_col
      logic [ValueBits-1:0] raw;
      mm_ram #(.Width(ValueBits), .Depth(MaxDim)) u_right (
        .clk(clk), .we(is_wr && d.op == OP_WRITE_RIGHT && d.col_index == 5'(c)),
        .waddr(d.row_index[IdxBits-1:0]), .wdata(d.element_value[ValueBits-1:0]),
        .raddr(k[IdxBits-1:0]), .rdata(raw));
      // skew column c through its delay chain so it meets a in cell c
      always_ff @(posedge clk) begin
        if (rst) begin
          for (int t = 0; t < MaxDim; t++) b_skew[c][t] <= '0;
        end else begin
          b_skew[c][0] <= v_rd ? raw : '0;
          for (int t = 1; t < MaxDim; t++) b_skew[c][t] <= b_skew[c][t-1];
        end
      end
      if (c == 0) begin : g_head
        assign b_rd[c] = v_rd ? raw : '0;
      end else begin : g_skew
        assign b_rd[c] = b_skew[c][c-1];
      end
      assign ctls[c] = '{clear: clear_go, enable: 1'b1};
      mm_cell u_cell (.clk(clk), .rst(rst), .ctl(ctls[c]), .a_in(a_ch[c]), .b_in(b_rd[c]),
        .a_out(a_ch[c+1]), .acc(accs[c]));
    end
  endgenerate
  // b_skew index c-1 delays column c by as many registers as a_ch[c] passes through

  always_ff @(posedge clk) begin
    if (rst) begin
      left_rows <= 6'd1; left_cols <= 6'd1; right_rows <= 6'd1; right_cols <= 6'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEFT_ROWS: left_rows <= cfg_data;
        REG_LEFT_COLS: left_cols <= cfg_data;
        REG_RIGHT_ROWS: right_rows <= cfg_data;
        REG_RIGHT_COLS: right_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; v_rd <= 1'b0; k <= '0; j <= '0; drain <= '0;
      out_valid <= 1'b0;
    end else begin
      v_rd <= feed_now;
      case (state)
        S_IDLE: begin
          if (clear_go && (IdxBits+1)'(d.row_index) < clampd(left_rows)
              && clampd(right_cols) != '0) begin
            row <= d.row_index[IdxBits-1:0];
            inner <= (left_cols != right_rows) ? '0 : clampd(left_cols);
            err <= (left_cols != right_rows);
            ncols <= clampd(right_cols);
            k <= '0;
            state <= S_FEED;
          end
        end
        S_FEED: begin
          if (feed_now) k <= k + 1'b1;
          else begin
            drain <= '0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drain == CntBits'(DrainLen)) begin
            j <= '0; state <= S_EMIT; out_valid <= 1'b1;
          end else drain <= drain + 1'b1;
        end
        S_EMIT: begin
          if (out_valid && out_ready) begin
            if (j + 1'b1 == ncols) begin
              out_valid <= 1'b0; state <= S_IDLE;
            end else j <= j + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_data.out_row = 5'(row);
    out_data.out_col = 5'(j[IdxBits-1:0]);
    out_data.product_value = err ? '0 : accs[j[IdxBits-1:0]];
    out_data.dim_error = err;
    out_data.last = (j + 1'b1 == ncols);
  end

  `MM_ASSERT_IMPL(a_out_emit, clk, rst, out_valid, state == S_EMIT)
  `MM_ASSERT_IMPL(a_idle_ready, clk, rst, in_ready, !out_valid)
  `MM_ASSERT_IMPL(a_col_range, clk, rst, out_valid, j < ncols)
  `MM_ASSERT_NEXT(a_last_done, clk, rst, out_valid && out_ready && out_data.last, !out_valid)
endmodule

/* src/mm_ram.sv */
// Generic single-port-write, registered-read RAM.
module mm_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/mm_cell.sv */
// One multiply-accumulate cell of the systolic row.
module mm_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  mm_pkg::cell_ctl_t                   ctl,
  input  logic signed [mm_pkg::ValueBits-1:0] a_in,
  input  logic signed [mm_pkg::ValueBits-1:0] b_in,
  output logic signed [mm_pkg::ValueBits-1:0] a_out,
  output logic signed [mm_pkg::SumBits-1:0]   acc
);
  import mm_pkg::*;

  logic signed [2*ValueBits-1:0] prod;

  // a passes down the chain one cell per cycle; b is this cell's column
  always_ff @(posedge clk) begin
    if (rst) begin
      a_out <= '0;
      prod <= '0;
      acc <= '0;
    end else begin
      a_out <= a_in;
      prod <= a_in * b_in;
      if (ctl.clear) begin
        acc <= '0;
      end else if (ctl.enable) begin
        acc <= acc + SumBits'(prod);
      end
    end
  end
endmodule
